[rtl/kms_pkg.sv]
// Shared types and constants of the key merge sorter.
package kms_pkg;

  localparam int IN_KEY_W          = 32;
  localparam int DEPTH_DEFAULT     = 32;
  localparam int KEY_WIDTH_DEFAULT = 32;
  localparam int QUEUE_DEPTH       = 2;
  localparam int MODE_W            = 2;

  // compare_mode bit positions
  localparam int MODE_DESC_BIT     = 0;
  localparam int MODE_SIGNED_BIT   = 1;

  typedef struct packed {
    logic [IN_KEY_W-1:0] key;
    logic                last;
    logic                keep;
    logic                ovf;
  } kms_entry_t;

  typedef enum logic [2:0] {
    BK_LOAD,
    BK_SETUP,
    BK_MERGE,
    BK_EMIT_RD,
    BK_EMIT_LOAD,
    BK_EMIT_HOLD
  } back_state_t;

endpackage

[rtl/kms_ram.sv]
// Generic RAM: one write port, two registered read ports.
module kms_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] ra_addr,
  output logic [WIDTH-1:0]         ra_data,
  input  logic [$clog2(DEPTH)-1:0] rb_addr,
  output logic [WIDTH-1:0]         rb_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    ra_data <= mem[ra_addr];
    rb_data <= mem[rb_addr];
  end

endmodule

[rtl/kms_front.sv]
// Front end: accepts keys, counts the batch, marks drops and overflow.
module kms_front
  import kms_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [IN_KEY_W-1:0] in_key,
  input  logic                in_is_last,
  input  logic                q_full,
  output logic                q_push,
  output kms_entry_t          q_entry
);

  localparam int CW = $clog2(DEPTH + 1);

  logic [CW-1:0] kept_r, kept_nxt;
  logic          ovf_r, ovf_nxt;
  logic          accept;
  logic          keep;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign keep     = kept_r < CW'(DEPTH);

  // dropped keys are not queued, but the last transaction always is
  assign q_push        = accept && (keep || in_is_last);
  assign q_entry.key   = in_key;
  assign q_entry.last  = in_is_last;
  assign q_entry.keep  = keep;
  assign q_entry.ovf   = ovf_r || !keep;

  always_comb begin
    kept_nxt = kept_r;
    ovf_nxt  = ovf_r;
    if (accept) begin
      if (in_is_last) begin
        kept_nxt = '0;
        ovf_nxt  = 1'b0;
      end else if (keep) begin
        kept_nxt = kept_r + CW'(1);
      end else begin
        ovf_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kept_r <= '0;
      ovf_r  <= 1'b0;
    end else begin
      kept_r <= kept_nxt;
      ovf_r  <= ovf_nxt;
    end
  end

endmodule

[rtl/kms_queue.sv]
// Short FIFO between front end and sort engine.
module kms_queue
  import kms_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  kms_entry_t push_entry,
  output logic       full,
  output logic       pop_valid,
  input  logic       pop_ready,
  output kms_entry_t pop_entry
);

  localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCW = $clog2(QUEUE_DEPTH + 1);

  kms_entry_t     slots_r [QUEUE_DEPTH];
  logic [QAW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCW-1:0] count_r, count_nxt;
  logic           do_pop;

  assign full      = count_r == QCW'(QUEUE_DEPTH);
  assign pop_valid = count_r != '0;
  assign pop_entry = slots_r[rd_ptr_r];
  assign do_pop    = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QAW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + QAW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QAW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + QAW'(1);
    end
    if (push && !do_pop) begin
      count_nxt = count_r + QCW'(1);
    end else if (do_pop && !push) begin
      count_nxt = count_r - QCW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_entry;
    end
  end

`ifndef SYNTH
  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("queue push while full");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCW'(QUEUE_DEPTH))
    else $error("queue count out of range");
`endif

endmodule

[rtl/kms_back.sv]
// Sort engine: stores a batch, bottom-up merge passes, then emits in order.
module kms_back
  import kms_pkg::*;
#(
  parameter int DEPTH     = DEPTH_DEFAULT,
  parameter int KEY_WIDTH = KEY_WIDTH_DEFAULT
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  kms_entry_t          q_entry,
  output logic                q_ready,
  input  logic [MODE_W-1:0]   mode,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [IN_KEY_W-1:0] out_sorted_key,
  output logic                out_last_out,
  output logic                out_overflowed
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int WW = CW + 1;
  localparam int SW = CW + 3;

  back_state_t state_r, state_nxt;

  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic           ovf_r, ovf_nxt;
  logic           src_r, src_nxt;
  logic [WW-1:0]  w_r, w_nxt;
  logic [CW-1:0]  i_r, i_nxt, j_r, j_nxt;
  logic [CW-1:0]  le_r, le_nxt, re_r, re_nxt;
  logic [CW-1:0]  k_r, k_nxt, e_r, e_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [IN_KEY_W-1:0] out_key_r, out_key_nxt;
  logic                out_last_r, out_last_nxt;
  logic                out_ovf_r, out_ovf_nxt;

  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [KEY_WIDTH-1:0] wr_data;
  logic [AW-1:0]        rd_a_addr, rd_b_addr;
  logic [KEY_WIDTH-1:0] r0a, r0b, r1a, r1b, rd_a, rd_b;
  logic                 ram0_we, ram1_we;

  logic [KEY_WIDTH-1:0] sign_flip, cmp_x, cmp_y;
  logic                 precedes, take_left, pass_done, blk_done;
  logic [CW-1:0]        lo_base, blk_mid, blk_end, load_n;
  logic [SW-1:0]        mid_s, end_s;

  assign rd_a = src_r ? r1a : r0a;
  assign rd_b = src_r ? r1b : r0b;

  // signed order: flip the sign bit, then compare unsigned
  assign sign_flip = mode[MODE_SIGNED_BIT] ? (KEY_WIDTH'(1) << (KEY_WIDTH - 1)) : '0;
  assign cmp_x     = rd_a ^ sign_flip;
  assign cmp_y     = rd_b ^ sign_flip;
  assign precedes  = mode[MODE_DESC_BIT] ? (cmp_x > cmp_y) : (cmp_x < cmp_y);

  // left head wins if the right run is used up or it strictly precedes; ties take the right
  assign take_left = (i_r < le_r) && (!(j_r < re_r) || precedes);
  assign pass_done = (k_r + CW'(1)) == cnt_r;
  assign blk_done  = (k_r + CW'(1)) == re_r;

  // bounds of the next pair of runs, clipped to the batch size
  assign lo_base = (state_r == BK_SETUP) ? '0 : re_r;
  assign mid_s   = SW'(lo_base) + SW'(w_r);
  assign end_s   = mid_s + SW'(w_r);
  assign blk_mid = (mid_s < SW'(cnt_r)) ? CW'(mid_s) : cnt_r;
  assign blk_end = (end_s < SW'(cnt_r)) ? CW'(end_s) : cnt_r;

  assign load_n = cnt_r + CW'(q_entry.keep);

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    ovf_nxt       = ovf_r;
    src_nxt       = src_r;
    w_nxt         = w_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    le_nxt        = le_r;
    re_nxt        = re_r;
    k_nxt         = k_r;
    e_nxt         = e_r;
    out_valid_nxt = out_valid_r;
    out_key_nxt   = out_key_r;
    out_last_nxt  = out_last_r;
    out_ovf_nxt   = out_ovf_r;
    q_ready       = 1'b0;
    wr_en         = 1'b0;
    wr_addr       = cnt_r[AW-1:0];
    wr_data       = KEY_WIDTH'(q_entry.key);
    case (state_r)
      BK_LOAD: begin
        q_ready = 1'b1;
        if (q_valid) begin
          if (q_entry.keep) begin
            wr_en   = 1'b1;
            cnt_nxt = load_n;
          end
          if (q_entry.last) begin
            ovf_nxt   = q_entry.ovf;
            src_nxt   = 1'b0;
            w_nxt     = WW'(1);
            e_nxt     = '0;
            state_nxt = (load_n > CW'(1)) ? BK_SETUP : BK_EMIT_RD;
          end
        end
      end
      BK_SETUP: begin
        i_nxt     = '0;
        j_nxt     = blk_mid;
        le_nxt    = blk_mid;
        re_nxt    = blk_end;
        k_nxt     = '0;
        state_nxt = BK_MERGE;
      end
      BK_MERGE: begin
        wr_en   = 1'b1;
        wr_addr = k_r[AW-1:0];
        wr_data = take_left ? rd_a : rd_b;
        k_nxt   = k_r + CW'(1);
        if (pass_done) begin
          w_nxt     = w_r << 1;
          src_nxt   = !src_r;
          state_nxt = ((SW'(w_r) << 1) >= SW'(cnt_r)) ? BK_EMIT_RD : BK_SETUP;
        end else if (blk_done) begin
          i_nxt  = re_r;
          j_nxt  = blk_mid;
          le_nxt = blk_mid;
          re_nxt = blk_end;
        end else if (take_left) begin
          i_nxt = i_r + CW'(1);
        end else begin
          j_nxt = j_r + CW'(1);
        end
      end
      BK_EMIT_RD: begin
        state_nxt = BK_EMIT_LOAD;
      end
      BK_EMIT_LOAD: begin
        out_valid_nxt = 1'b1;
        out_key_nxt   = IN_KEY_W'(rd_a);
        out_last_nxt  = (e_r + CW'(1)) == cnt_r;
        out_ovf_nxt   = ovf_r;
        state_nxt     = BK_EMIT_HOLD;
      end
      BK_EMIT_HOLD: begin
        if (out_ready) begin
          out_valid_nxt = 1'b0;
          if (out_last_r) begin
            cnt_nxt   = '0;
            ovf_nxt   = 1'b0;
            state_nxt = BK_LOAD;
          end else begin
            e_nxt     = e_r + CW'(1);
            state_nxt = BK_EMIT_LOAD;
          end
        end
      end
      default: begin
        state_nxt = BK_LOAD;
      end
    endcase
  end

  // read addresses follow the next indices so data lines up with i_r / j_r
  assign rd_a_addr = (state_r == BK_SETUP || state_r == BK_MERGE) ?
                     i_nxt[AW-1:0] : e_nxt[AW-1:0];
  assign rd_b_addr = j_nxt[AW-1:0];

  assign ram0_we = wr_en && ((state_r == BK_LOAD) || src_r);
  assign ram1_we = wr_en && (state_r == BK_MERGE) && !src_r;

  kms_ram #(
    .WIDTH (KEY_WIDTH),
    .DEPTH (DEPTH)
  ) u_key_store (
    .clk     (clk),
    .we      (ram0_we),
    .waddr   (wr_addr),
    .wdata   (wr_data),
    .ra_addr (rd_a_addr),
    .ra_data (r0a),
    .rb_addr (rd_b_addr),
    .rb_data (r0b)
  );

  kms_ram #(
    .WIDTH (KEY_WIDTH),
    .DEPTH (DEPTH)
  ) u_merge_buffer (
    .clk     (clk),
    .we      (ram1_we),
    .waddr   (wr_addr),
    .wdata   (wr_data),
    .ra_addr (rd_a_addr),
    .ra_data (r1a),
    .rb_addr (rd_b_addr),
    .rb_data (r1b)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_LOAD;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    src_r      <= src_nxt;
    w_r        <= w_nxt;
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    le_r       <= le_nxt;
    re_r       <= re_nxt;
    k_r        <= k_nxt;
    e_r        <= e_nxt;
    out_key_r  <= out_key_nxt;
    out_last_r <= out_last_nxt;
    out_ovf_r  <= out_ovf_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_sorted_key = out_key_r;
  assign out_last_out   = out_last_r;
  assign out_overflowed = out_ovf_r;

`ifndef SYNTH
  a_merge_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_MERGE) |-> (k_r < cnt_r && i_r <= le_r && j_r <= re_r))
    else $error("merge index out of bounds");

  a_no_output_while_loading: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_LOAD) |-> !out_valid_r)
    else $error("output valid while loading");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("key count exceeds capacity");
`endif

endmodule

[rtl/key_merge_sorter_core.sv]
// Top level of the key merge sorter.
//
//  channel  direction  handshake          payload
//  cfg      in         cfg_valid/ready    cfg_compare_mode
//  in       in         in_valid/ready     in_key, in_is_last
//  out      out        out_valid/ready    out_sorted_key, out_last_out, out_overflowed
//
// Keys are taken one per cycle, while the queue has room, into a 2-entry queue and
// written to the key RAM one per cycle. The last key starts ceil(log2(n)) merge passes,
// each a setup state then one comparator and one RAM write per cycle, then a read
// state, then each key passes a load and a hold state into a registered output.
// Reset is synchronous, active low; the RAMs need no clearing.
// While the engine sorts or waits on out_ready, input fills the queue, then stalls.
module key_merge_sorter_core
  import kms_pkg::*;
#(
  parameter int DEPTH     = DEPTH_DEFAULT,
  parameter int KEY_WIDTH = KEY_WIDTH_DEFAULT
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [MODE_W-1:0]   cfg_compare_mode,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [IN_KEY_W-1:0] in_key,
  input  logic                in_is_last,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [IN_KEY_W-1:0] out_sorted_key,
  output logic                out_last_out,
  output logic                out_overflowed
);

  logic [MODE_W-1:0] compare_mode_r;
  logic              q_full, q_push, q_valid, q_ready;
  kms_entry_t        push_entry, pop_entry;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      compare_mode_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      compare_mode_r <= cfg_compare_mode;
    end
  end

  kms_front #(
    .DEPTH (DEPTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_key     (in_key),
    .in_is_last (in_is_last),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_entry    (push_entry)
  );

  kms_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_entry  (pop_entry)
  );

  kms_back #(
    .DEPTH     (DEPTH),
    .KEY_WIDTH (KEY_WIDTH)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_entry        (pop_entry),
    .q_ready        (q_ready),
    .mode           (compare_mode_r),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_sorted_key (out_sorted_key),
    .out_last_out   (out_last_out),
    .out_overflowed (out_overflowed)
  );

endmodule

[dv/tb_key_merge_sorter_core.sv]
// Testbench for key_merge_sorter_core: batch sorting in all four orders vs. a predictor.
`timescale 1ns / 1ps

module tb_key_merge_sorter_core;
  import kms_pkg::*;

  localparam int  CLK_PERIOD  = 20;
  localparam int  CAPACITY    = DEPTH_DEFAULT;
  localparam int  RAND_ITEMS  = 200;
  localparam int  SETTLE_CYC  = 40;
  localparam int  MAX_PRINTS  = 30;
  localparam time TIMEOUT_NS  = 4_000_000;

  localparam logic [MODE_W-1:0] MODE_UNS_ASC  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_UNS_DESC = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SGN_ASC  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_SGN_DESC = 2'd3;

  typedef struct {
    logic [IN_KEY_W-1:0] key;
    logic                last;
    logic                ovf;
  } sorted_item_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [MODE_W-1:0]   cfg_compare_mode = '0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [IN_KEY_W-1:0] in_key = '0;
  logic                in_is_last = 1'b0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [IN_KEY_W-1:0] out_sorted_key;
  logic                out_last_out;
  logic                out_overflowed;

  key_merge_sorter_core u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_compare_mode (cfg_compare_mode),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_key           (in_key),
    .in_is_last       (in_is_last),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_sorted_key   (out_sorted_key),
    .out_last_out     (out_last_out),
    .out_overflowed   (out_overflowed)
  );

  // predictor state
  logic [MODE_W-1:0]   sort_mode = MODE_UNS_ASC;
  logic [IN_KEY_W-1:0] pending_keys[$];
  logic                pending_ovf = 1'b0;
  sorted_item_t        expected_sorted[$];

  // stimulus scratch and bookkeeping
  logic [IN_KEY_W-1:0] batch_buf[$];
  int                  burst_left = 0;
  int                  error_count = 0;
  int                  keys_sent = 0;
  int                  batches_sent = 0;
  int                  ovf_batches = 0;
  int                  results_seen = 0;
  int                  mode_writes = 0;

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("timeout with %0d results still expected", expected_sorted.size());
    $display("FAIL key_merge_sorter_core");
    $finish;
  end

  function automatic logic key_precedes(input logic [IN_KEY_W-1:0] a,
                                        input logic [IN_KEY_W-1:0] b,
                                        input logic [MODE_W-1:0]   mode);
    logic [IN_KEY_W-1:0] x;
    logic [IN_KEY_W-1:0] y;
    x = a;
    y = b;
    if (mode[MODE_SIGNED_BIT]) begin
      x[IN_KEY_W-1] = ~x[IN_KEY_W-1];
      y[IN_KEY_W-1] = ~y[IN_KEY_W-1];
    end
    if (mode[MODE_DESC_BIT]) return x > y;
    return x < y;
  endfunction

  // Equal keys are indistinguishable, so any correct ordering matches the merge order.
  task automatic sort_and_expect();
    int                  i;
    int                  j;
    logic [IN_KEY_W-1:0] v;
    sorted_item_t        item;
    for (i = 1; i < pending_keys.size(); i++) begin
      v = pending_keys[i];
      j = i;
      while (j > 0 && key_precedes(v, pending_keys[j-1], sort_mode)) begin
        pending_keys[j] = pending_keys[j-1];
        j--;
      end
      pending_keys[j] = v;
    end
    for (i = 0; i < pending_keys.size(); i++) begin
      item.key  = pending_keys[i];
      item.last = (i == pending_keys.size() - 1);
      item.ovf  = pending_ovf;
      expected_sorted.push_back(item);
    end
    if (pending_ovf) ovf_batches++;
    batches_sent++;
    pending_keys.delete();
    pending_ovf = 1'b0;
  endtask

  task automatic predict_key(input logic [IN_KEY_W-1:0] k, input logic l);
    if (pending_keys.size() < CAPACITY) pending_keys.push_back(k);
    else pending_ovf = 1'b1;
    if (l) sort_and_expect();
  endtask

  // Sends one key; bursts of random length separated by random gaps.
  task automatic send_key(input logic [IN_KEY_W-1:0] k, input logic l);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 80)
                                               : $urandom_range(1, 12);
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    burst_left--;
    in_valid   <= 1'b1;
    in_key     <= k;
    in_is_last <= l;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    keys_sent++;
    predict_key(k, l);
  endtask

  task automatic send_batch();
    int i;
    for (i = 0; i < batch_buf.size(); i++) send_key(batch_buf[i], i == batch_buf.size() - 1);
    batch_buf.delete();
  endtask

  // Stop sending and wait until every expected result is out and the block settles.
  task automatic drain();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (expected_sorted.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_mode(input logic [MODE_W-1:0] m);
    cfg_valid        <= 1'b1;
    cfg_compare_mode <= m;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sort_mode = m;
    mode_writes++;
  endtask

  function automatic logic [IN_KEY_W-1:0] rand_key();
    case ($urandom_range(0, 4))
      0:       return $urandom_range(0, 7);
      1:       return 32'h7FFF_FFF0 + $urandom_range(0, 31);
      2: begin
        case ($urandom_range(0, 3))
          0:       return 32'h0000_0000;
          1:       return 32'hFFFF_FFFF;
          2:       return 32'h8000_0000;
          default: return 32'h7FFF_FFFF;
        endcase
      end
      default: return $urandom();
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [IN_KEY_W-1:0] got,
                                 input logic [IN_KEY_W-1:0] want);
    if (error_count < MAX_PRINTS)
      $display("%0t mismatch on %s: got %h want %h (result %0d)",
               $realtime, what, got, want, results_seen);
    error_count++;
  endtask

  // Receiver: stall style changes every so often.
  int   stall_style = 0;
  int   stall_left = 0;
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_style = $urandom_range(0, 3);
      stall_left  = $urandom_range(20, 200);
    end
    stall_left--;
    case (stall_style)
      0:       out_ready <= 1'b1;
      1:       out_ready <= 1'($urandom_range(0, 1));
      2:       out_ready <= ($urandom_range(0, 3) == 0);
      default: if ($urandom_range(0, 15) == 0) out_ready <= ~out_ready;
    endcase
  end

  always @(posedge clk) begin : result_check
    sorted_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_sorted.size() == 0) begin
        report_mismatch("unexpected transaction", out_sorted_key, '0);
      end else begin
        want = expected_sorted.pop_front();
        if (out_sorted_key !== want.key) report_mismatch("sorted_key", out_sorted_key, want.key);
        if (out_last_out !== want.last)
          report_mismatch("last_out", {31'b0, out_last_out}, {31'b0, want.last});
        if (out_overflowed !== want.ovf)
          report_mismatch("overflowed", {31'b0, out_overflowed}, {31'b0, want.ovf});
      end
      results_seen++;
    end
  end

  // Batch sent before any write checks the reset order.
  task automatic test_reset_mode();
    batch_buf = '{32'h0000_0003, 32'hFFFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'h0000_0003};
    send_batch();
    drain();
  endtask

  task automatic test_orders();
    logic [MODE_W-1:0] modes[3];
    int                i;
    modes = '{MODE_UNS_DESC, MODE_SGN_ASC, MODE_SGN_DESC};
    for (i = 0; i < 3; i++) begin
      write_mode(modes[i]);
      batch_buf = '{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000,
                    32'h7FFF_FFFF};
      send_batch();
      drain();
    end
  endtask

  task automatic test_single_key();
    write_mode(MODE_UNS_ASC);
    batch_buf = '{32'hA5A5_5A5A};
    send_batch();
    drain();
  endtask

  // One key past capacity, carrying the end marker: it is dropped but still ends the batch.
  task automatic test_overflow();
    int i;
    write_mode(MODE_SGN_DESC);
    for (i = 0; i <= CAPACITY; i++) batch_buf.push_back($urandom());
    send_batch();
    drain();
  endtask

  task automatic test_random();
    int sent;
    int n;
    int i;
    int pick;
    sent = 0;
    n    = 0;
    while (sent < RAND_ITEMS) begin
      if (n % 4 == 3) begin
        drain();
        write_mode(MODE_W'($urandom_range(0, 3)));
      end
      pick = $urandom_range(0, 19);
      if (pick < 14)      n = $urandom_range(1, 8);
      else if (pick < 18) n = $urandom_range(9, CAPACITY - 1);
      else if (pick < 19) n = CAPACITY;
      else                n = $urandom_range(CAPACITY + 1, CAPACITY + 8);
      for (i = 0; i < n; i++) batch_buf.push_back(rand_key());
      send_batch();
      sent += n;
    end
    drain();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_mode();
    test_orders();
    test_single_key();
    test_overflow();
    test_random();
    $display("covered %0d batches (%0d with overflow), %0d keys sent, %0d results checked",
             batches_sent, ovf_batches, keys_sent, results_seen);
    $display("compare mode written %0d times across all four orders", mode_writes);
    if (error_count == 0) begin
      $display("PASS key_merge_sorter_core");
    end else begin
      $display("%0d mismatches", error_count);
      $display("FAIL key_merge_sorter_core");
    end
    $finish;
  end

endmodule
